@@ design/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg: shared definitions for the best-fit free list allocator
// Field widths, command and status codes, and the control/status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int CMD_W     = 2;
  localparam int ID_W      = 16;
  localparam int FLD_LEN_W = 16;
  localparam int POS_W     = 7;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 8;

  localparam int DEF_MAX_BLOCKS  = 128;
  localparam int DEF_LENGTH_BITS = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_LOADED    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_SPLIT     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXACT     = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_READ_OK   = 3'd5;
  localparam logic [STATUS_W-1:0] STATUS_INVALID   = 3'd6;

  // scan phase: best-fit search, search for the successor of a removed
  // block, or walk to the k-th live block
  typedef enum logic [1:0] {
    PH_ALLOC,
    PH_NEXT,
    PH_READ
  } phase_e;

  typedef struct packed {
    logic   start;
    logic   step;
    phase_e phase;
  } ctrl_cmd_t;

  typedef struct packed {
    logic quick;
    logic is_read;
    logic exact;
    logic done;
  } dp_stat_t;

endpackage

@@ design/bfa_if.sv @@
// ----------------------------------------------------------------------------
// bfa_if: handshake channels of the allocator
// Request channel (bfa_in_if) and result channel (bfa_out_if), each with
// valid, ready and the word's fields.
// ----------------------------------------------------------------------------
interface bfa_in_if;
  logic                           valid;
  logic                           ready;
  logic [bfa_pkg::CMD_W-1:0]      command;
  logic [bfa_pkg::ID_W-1:0]       block_id;
  logic [bfa_pkg::FLD_LEN_W-1:0]  block_length;
  logic [bfa_pkg::FLD_LEN_W-1:0]  request_size;
  logic [bfa_pkg::POS_W-1:0]      position;

  modport source (
    output valid, command, block_id, block_length, request_size, position,
    input  ready
  );
  modport sink (
    input  valid, command, block_id, block_length, request_size, position,
    output ready
  );
endinterface

interface bfa_out_if;
  logic                           valid;
  logic                           ready;
  logic [bfa_pkg::STATUS_W-1:0]   status;
  logic [bfa_pkg::ID_W-1:0]       result_id;
  logic [bfa_pkg::FLD_LEN_W-1:0]  result_length;
  logic [bfa_pkg::COUNT_W-1:0]    live_count;

  modport source (
    output valid, status, result_id, result_length, live_count,
    input  ready
  );
  modport sink (
    input  valid, status, result_id, result_length, live_count,
    output ready
  );
endinterface

@@ design/best_fit_free_list_allocator_top.sv @@
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator_top: best-fit allocator over a circular list
// Request words on in_i (load, allocate, read); one result word per request
// on out_o. Blocks live in a one-read, one-write store scanned from the rover.
// ----------------------------------------------------------------------------
// Usage
//   in_i  : command, block_id, block_length, request_size, position.
//   out_o : status, result_id, result_length, live_count.
//   One request is in flight at a time. in_i.ready drops on accept and rises
//   again in the cycle after the result word is taken.
//   Load, refused and invalid words are answered without a slot scan. A read
//   walks the loaded slots from the rover to the k-th live block. An allocate
//   scans the loaded slots from the rover for the best fit; an exact hit ends
//   that scan and, unless it removed the last live block, a search for the
//   successor of the removed block follows. The scan visits one slot per
//   cycle through the store's single read port; that port sets the rate.
//   Reset empties the list and clears the exhausted state; the store needs
//   no clearing pass. A stalled result holds out_o steady and no new request
//   is taken until it is accepted.
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator_top #(
  parameter int MAX_BLOCKS  = bfa_pkg::DEF_MAX_BLOCKS,
  parameter int LENGTH_BITS = bfa_pkg::DEF_LENGTH_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfa_in_if.sink     in_i,
  bfa_out_if.source  out_o
);
  import bfa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  bfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bfa_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .command_i       (in_i.command),
    .block_id_i      (in_i.block_id),
    .block_length_i  (in_i.block_length),
    .request_size_i  (in_i.request_size),
    .position_i      (in_i.position),
    .status_o        (out_o.status),
    .result_id_o     (out_o.result_id),
    .result_length_o (out_o.result_length),
    .live_count_o    (out_o.live_count)
  );

endmodule

@@ design/bfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfa_ctrl: allocator sequencer
// Owns the handshakes, starts the datapath on an accepted word, steps the
// slot scan through its phases and holds the result until it is taken.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  bfa_pkg::dp_stat_t   stat_i,
  output bfa_pkg::ctrl_cmd_t  cmd_o
);
  import bfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e state_q;
  phase_e phase_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   accept;

  assign accept      = in_valid_i && in_ready_q;
  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  assign cmd_o.start = accept;
  assign cmd_o.step  = (state_q == S_SCAN);
  assign cmd_o.phase = phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_ALLOC;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            in_ready_q <= 1'b0;
            if (stat_i.quick) begin
              state_q     <= S_RESULT;
              out_valid_q <= 1'b1;
            end else begin
              state_q <= S_SCAN;
              phase_q <= stat_i.is_read ? PH_READ : PH_ALLOC;
            end
          end
        end
        S_SCAN: begin
          if (stat_i.done) begin
            state_q     <= S_RESULT;
            out_valid_q <= 1'b1;
          end else if (stat_i.exact) begin
            phase_q <= PH_NEXT;
          end
        end
        S_RESULT: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ design/bfa_dp.sv @@
// ----------------------------------------------------------------------------
// bfa_dp: allocator datapath
// Block store (one write, one registered read per cycle), list counters,
// rover, one-slot-per-cycle scan with best-fit tracking, result register.
// ----------------------------------------------------------------------------
module bfa_dp #(
  parameter int MAX_BLOCKS  = bfa_pkg::DEF_MAX_BLOCKS,
  parameter int LENGTH_BITS = bfa_pkg::DEF_LENGTH_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bfa_pkg::ctrl_cmd_t             cmd_i,
  output bfa_pkg::dp_stat_t              stat_o,
  input  logic [bfa_pkg::CMD_W-1:0]      command_i,
  input  logic [bfa_pkg::ID_W-1:0]       block_id_i,
  input  logic [bfa_pkg::FLD_LEN_W-1:0]  block_length_i,
  input  logic [bfa_pkg::FLD_LEN_W-1:0]  request_size_i,
  input  logic [bfa_pkg::POS_W-1:0]      position_i,
  output logic [bfa_pkg::STATUS_W-1:0]   status_o,
  output logic [bfa_pkg::ID_W-1:0]       result_id_o,
  output logic [bfa_pkg::FLD_LEN_W-1:0]  result_length_o,
  output logic [bfa_pkg::COUNT_W-1:0]    live_count_o
);
  import bfa_pkg::*;

  localparam int SW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int KW = (CW > POS_W) ? CW : POS_W;
  localparam int MW = 1 + ID_W + LENGTH_BITS;

  // store word: {live, id, length}
  logic [MW-1:0] mem [MAX_BLOCKS];
  logic [MW-1:0] rd_q;

  logic [CW-1:0]          loaded_q, live_q;
  logic [SW-1:0]          rover_q, iss_q, iss_nx, rd_slot_q, eval_q;
  logic                   exh_q, rd_valid_q;
  logic [LENGTH_BITS-1:0] req_q;
  logic [KW-1:0]          pos_q, found_q;
  logic                   have_best_q;
  logic [SW-1:0]          best_slot_q;
  logic [ID_W-1:0]        best_id_q;
  logic [LENGTH_BITS-1:0] best_len_q;
  logic [STATUS_W-1:0]    res_status_q;
  logic [ID_W-1:0]        res_id_q;
  logic [FLD_LEN_W-1:0]   res_len_q;

  logic [LENGTH_BITS-1:0] len_in, req_in;
  logic [KW-1:0]          pos_in;
  logic                   full, quick, load_ok;
  logic [STATUS_W-1:0]    q_status;
  logic [ID_W-1:0]        q_id;
  logic [FLD_LEN_W-1:0]   q_len;

  logic                   ev, ev_live, is_exact, better, last_eval, last_live;
  logic [ID_W-1:0]        ev_id;
  logic [LENGTH_BITS-1:0] ev_len;
  logic                   nb_have;
  logic [SW-1:0]          nb_slot;
  logic [ID_W-1:0]        nb_id;
  logic [LENGTH_BITS-1:0] nb_len, split_len;

  logic                   we;
  logic [SW-1:0]          waddr;
  logic [MW-1:0]          wdata;

  assign len_in  = LENGTH_BITS'(block_length_i);
  assign req_in  = LENGTH_BITS'(request_size_i);
  assign pos_in  = KW'(position_i);
  assign full    = (loaded_q == CW'(MAX_BLOCKS));
  assign load_ok = !exh_q && !full;

  always_comb begin
    quick    = 1'b1;
    q_status = STATUS_INVALID;
    q_id     = '0;
    q_len    = '0;
    case (command_i)
      CMD_LOAD: begin
        if (load_ok) begin
          q_status = STATUS_LOADED;
          q_id     = block_id_i;
          q_len    = FLD_LEN_W'(len_in);
        end
      end
      CMD_ALLOC: begin
        quick = exh_q || (req_in == '0) || (live_q == '0);
        if (exh_q) begin
          q_status = STATUS_EXHAUSTED;
        end else if (req_in == '0) begin
          q_status = STATUS_INVALID;
        end else begin
          q_status = STATUS_NOFIT;
        end
      end
      CMD_READ: begin
        quick = (live_q == '0) || (pos_in >= KW'(live_q));
      end
      default: begin
        quick = 1'b1;
      end
    endcase
  end

  // scan evaluation of the slot read in the previous cycle
  assign ev        = rd_valid_q && cmd_i.step;
  assign ev_live   = rd_q[MW-1];
  assign ev_id     = rd_q[MW-2 -: ID_W];
  assign ev_len    = rd_q[LENGTH_BITS-1:0];
  assign is_exact  = ev_live && (ev_len == req_q);
  assign better    = ev_live && (ev_len > req_q) && (!have_best_q || (ev_len < best_len_q));
  assign last_eval = (CW'(eval_q) == loaded_q - CW'(1));
  assign last_live = (live_q == CW'(1));
  assign nb_have   = have_best_q || better;
  assign nb_slot   = better ? rd_slot_q : best_slot_q;
  assign nb_id     = better ? ev_id : best_id_q;
  assign nb_len    = better ? ev_len : best_len_q;
  assign split_len = nb_len - req_q;
  assign iss_nx    = (CW'(iss_q) == loaded_q - CW'(1)) ? '0 : iss_q + SW'(1);

  always_comb begin
    stat_o.quick   = quick;
    stat_o.is_read = (command_i == CMD_READ);
    stat_o.exact   = ev && (cmd_i.phase == PH_ALLOC) && is_exact && !last_live;
    stat_o.done    = 1'b0;
    if (ev) begin
      case (cmd_i.phase)
        PH_ALLOC: stat_o.done = is_exact ? last_live : last_eval;
        PH_NEXT:  stat_o.done = ev_live;
        PH_READ:  stat_o.done = ev_live && (found_q == pos_q);
        default:  stat_o.done = 1'b0;
      endcase
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = loaded_q[SW-1:0];
    wdata = {1'b1, block_id_i, len_in};
    if (cmd_i.start && quick && (command_i == CMD_LOAD) && load_ok) begin
      we = 1'b1;
    end else if (ev && (cmd_i.phase == PH_ALLOC)) begin
      if (is_exact) begin
        we    = 1'b1;
        waddr = rd_slot_q;
        wdata = {1'b0, ev_id, ev_len};
      end else if (last_eval && nb_have) begin
        we    = 1'b1;
        waddr = nb_slot;
        wdata = {1'b1, nb_id, split_len};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[iss_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q     <= '0;
      live_q       <= '0;
      rover_q      <= '0;
      exh_q        <= 1'b0;
      iss_q        <= '0;
      rd_valid_q   <= 1'b0;
      rd_slot_q    <= '0;
      eval_q       <= '0;
      found_q      <= '0;
      req_q        <= '0;
      pos_q        <= '0;
      have_best_q  <= 1'b0;
      best_slot_q  <= '0;
      best_id_q    <= '0;
      best_len_q   <= '0;
      res_status_q <= STATUS_INVALID;
      res_id_q     <= '0;
      res_len_q    <= '0;
    end else begin
      rd_valid_q <= cmd_i.step;
      rd_slot_q  <= iss_q;
      if (cmd_i.start) begin
        iss_q       <= rover_q;
        eval_q      <= '0;
        found_q     <= '0;
        have_best_q <= 1'b0;
        req_q       <= req_in;
        pos_q       <= pos_in;
        if (quick) begin
          res_status_q <= q_status;
          res_id_q     <= q_id;
          res_len_q    <= q_len;
          if ((command_i == CMD_LOAD) && load_ok) begin
            loaded_q <= loaded_q + CW'(1);
            live_q   <= live_q + CW'(1);
            if (live_q == '0) begin
              rover_q <= loaded_q[SW-1:0];
            end
          end
        end
      end else if (cmd_i.step) begin
        iss_q <= iss_nx;
        if (ev) begin
          case (cmd_i.phase)
            PH_ALLOC: begin
              eval_q      <= eval_q + SW'(1);
              have_best_q <= nb_have;
              best_slot_q <= nb_slot;
              best_id_q   <= nb_id;
              best_len_q  <= nb_len;
              if (is_exact) begin
                live_q    <= live_q - CW'(1);
                res_id_q  <= ev_id;
                res_len_q <= '0;
                if (last_live) begin
                  exh_q        <= 1'b1;
                  res_status_q <= STATUS_EXHAUSTED;
                end else begin
                  res_status_q <= STATUS_EXACT;
                end
              end else if (last_eval) begin
                if (nb_have) begin
                  rover_q      <= nb_slot;
                  res_status_q <= STATUS_SPLIT;
                  res_id_q     <= nb_id;
                  res_len_q    <= FLD_LEN_W'(split_len);
                end else begin
                  res_status_q <= STATUS_NOFIT;
                  res_id_q     <= '0;
                  res_len_q    <= '0;
                end
              end
            end
            PH_NEXT: begin
              if (ev_live) begin
                rover_q <= rd_slot_q;
              end
            end
            PH_READ: begin
              if (ev_live) begin
                if (found_q == pos_q) begin
                  res_status_q <= STATUS_READ_OK;
                  res_id_q     <= ev_id;
                  res_len_q    <= FLD_LEN_W'(ev_len);
                end else begin
                  found_q <= found_q + KW'(1);
                end
              end
            end
            default: begin
              rover_q <= rover_q;
            end
          endcase
        end
      end
    end
  end

  assign status_o        = res_status_q;
  assign result_id_o     = res_id_q;
  assign result_length_o = res_len_q;
  assign live_count_o    = COUNT_W'(live_q);

endmodule

@@ design/bfa_checker.sv @@
// ----------------------------------------------------------------------------
// bfa_checker: port-level checks for the allocator
// Result word hold under stall, one word in flight, and status/field rules.
// ----------------------------------------------------------------------------
module bfa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [bfa_pkg::STATUS_W-1:0]   status_i,
  input logic [bfa_pkg::ID_W-1:0]       result_id_i,
  input logic [bfa_pkg::FLD_LEN_W-1:0]  result_length_i,
  input logic [bfa_pkg::COUNT_W-1:0]    live_count_i
);
  import bfa_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(result_id_i) && $stable(result_length_i))
    else $error("result word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i)
    else $error("request taken while a result word is pending");

  a_refusal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STATUS_NOFIT || status_i == STATUS_INVALID)
      |-> result_id_i == '0 && result_length_i == '0)
    else $error("refused word carries block fields");

  a_removed_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STATUS_EXACT || status_i == STATUS_EXHAUSTED)
      |-> result_length_i == '0)
    else $error("removed block reports a length");

  a_exhausted_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_EXHAUSTED |-> live_count_i == '0)
    else $error("exhausted with live blocks left");

endmodule

bind best_fit_free_list_allocator_top bfa_checker u_bfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .result_id_i     (out_o.result_id),
  .result_length_i (out_o.result_length),
  .live_count_i    (out_o.live_count)
);
